/* rtl/dlps_pkg.sv */
// ----------------------------------------------------------------------------
// Delay-line pitch shifter package
// Shared types, constants and the sine weight table.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam logic [15:0] UNITY_RATIO = 16'd4096;
    localparam logic [15:0] RATIO_RESET = 16'd4096;
    localparam logic [11:0] WIN_RESET   = 12'd1056;

    localparam logic [15:0] SINE_Q15 [33] = '{
        16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
        16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
        16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
        16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
        16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
        16'd32610, 16'd32729, 16'd32768
    };

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TAP  = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_QUOT = 8'b0000_1000,
        ST_MOD  = 8'b0001_0000,
        ST_READ = 8'b0010_0000,
        ST_MAC  = 8'b0100_0000,
        ST_SUM  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_out;
    } t_cmd;

    function automatic logic [15:0] sine_at(input logic [7:0] i);
        logic [7:0] k;
        k = (i > 8'd64) ? 8'd64 : i;
        if (k <= 8'd32) begin
            return SINE_Q15[k[5:0]];
        end else begin
            return SINE_Q15[6'(8'd64 - k)];
        end
    endfunction

endpackage

/* rtl/dlps_div.sv */
// ----------------------------------------------------------------------------
// Phase increment divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_numer,
    input  logic [12:0] i_denom,
    output logic        o_busy,
    output logic [23:0] o_quot
);

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [29:0] r_num, n_num;
    logic [29:0] r_quo, n_quo;
    logic [12:0] r_rem, n_rem;
    logic [12:0] r_den, n_den;
    logic [13:0] rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        rem_sh = {r_rem, r_num[29]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_num  = i_numer;
            n_quo  = 30'd0;
            n_rem  = 13'd0;
            n_den  = i_denom;
        end else if (r_busy) begin
            n_num = {r_num[28:0], 1'b0};
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = 13'(rem_sh - {1'b0, r_den});
                n_quo = {r_quo[28:0], 1'b1};
            end else begin
                n_rem = rem_sh[12:0];
                n_quo = {r_quo[28:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd29) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
            r_quo  <= 30'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_quo  <= n_quo;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo[23:0];

endmodule

/* rtl/dlps_ctrl.sv */
// ----------------------------------------------------------------------------
// Pitch shifter controller
// Sequences one word through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module dlps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_busy,
    output dlps_pkg::t_cmd o_cmd
);

    dlps_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             ready;
    logic             load;

    assign ready = (r_state == dlps_pkg::ST_IDLE) && !i_busy;
    assign load  = (r_state == dlps_pkg::ST_SUM) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dlps_pkg::ST_IDLE: begin
                if (ready && i_in_valid) n_state = dlps_pkg::ST_TAP;
            end
            dlps_pkg::ST_TAP:  n_state = dlps_pkg::ST_MUL;
            dlps_pkg::ST_MUL:  n_state = dlps_pkg::ST_QUOT;
            dlps_pkg::ST_QUOT: n_state = dlps_pkg::ST_MOD;
            dlps_pkg::ST_MOD:  n_state = dlps_pkg::ST_READ;
            dlps_pkg::ST_READ: n_state = dlps_pkg::ST_MAC;
            dlps_pkg::ST_MAC:  n_state = dlps_pkg::ST_SUM;
            dlps_pkg::ST_SUM: begin
                if (load) n_state = dlps_pkg::ST_IDLE;
            end
            default: n_state = dlps_pkg::ST_IDLE;
        endcase
        n_out_valid = load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlps_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = ready;
    assign o_out_valid     = r_out_valid;
    assign o_cmd.accept    = ready && i_in_valid;
    assign o_cmd.load_out  = load;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |-> !o_in_ready) else $error("word accepted during divide");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == dlps_pkg::ST_TAP)) else $error("sequence not started");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid) else $error("result lost");
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dlps_pkg::ST_IDLE) |-> !o_in_ready) else $error("overlap");

endmodule

/* rtl/dlps_dp.sv */
// ----------------------------------------------------------------------------
// Pitch shifter datapath
// Delay memory, phase accumulator, tap address and weight arithmetic.
// ----------------------------------------------------------------------------
module dlps_dp #(
    parameter int DELAY_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlps_pkg::t_cmd     i_cmd,
    input  logic signed [23:0] i_in_sample,
    input  logic [15:0]        i_ratio,
    input  logic [11:0]        i_win,
    input  logic [23:0]        i_inc,
    output logic signed [23:0] o_out_sample
);

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW = ((AW > 12) ? AW : 12) + 1;
    localparam logic [29:0] RECIP = 30'(((64'd1 << 30) + 64'(DELAY_DEPTH) - 64'd1)
                                        / 64'(DELAY_DEPTH));
    localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

    logic signed [23:0] r_mem [DELAY_DEPTH];

    logic [AW-1:0] r_wp, r_newest;
    logic [AW:0]   r_fill;
    logic [23:0]   r_phase;
    logic [24:0]   r_tap1, r_tap2;
    logic [11:0]   r_d1, r_d2, r_q1, r_q2, r_dd1, r_dd2;
    logic [34:0]   r_pa1, r_pa2;
    logic [33:0]   r_pb1, r_pb2;
    logic [15:0]   r_w1, r_w2;
    logic signed [23:0] r_rd1, r_rd2;
    logic          r_v1, r_v2;
    logic signed [40:0] r_m1, r_m2;
    logic signed [23:0] r_out;

    logic [11:0]   wsafe;
    logic [24:0]   tap1;
    logic [23:0]   tap2;
    logic [AW-1:0] idx1, idx2;

    function automatic logic [11:0] delay_of(input logic [24:0] t, input logic [11:0] w);
        logic [37:0] p;
        p = 38'(t) * 38'(w) + 38'd8388608;
        return p[35:24];
    endfunction

    function automatic logic [11:0] quot_of(input logic [11:0] d);
        logic [41:0] p;
        p = 42'(d) * 42'(RECIP);
        return p[41:30];
    endfunction

    function automatic logic [11:0] mod_of(input logic [11:0] d, input logic [11:0] q);
        logic [29:0] p;
        p = 30'(q) * 30'(DELAY_DEPTH);
        return 12'(30'(d) - p);
    endfunction

    function automatic logic [AW-1:0] index_of(input logic [AW-1:0] nw,
                                               input logic [11:0] dd);
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        a = CW'(nw);
        b = CW'(dd);
        if (a >= b) begin
            return AW'(a - b);
        end else begin
            return AW'(a + DEPTH_C - b);
        end
    endfunction

    assign wsafe = (i_win == 12'd0) ? 12'd1 : i_win;
    assign tap1  = (i_ratio > dlps_pkg::UNITY_RATIO) ? (25'h1000000 - 25'(r_phase))
                                                     : 25'(r_phase);
    assign tap2  = tap1[23:0] + 24'h800000;
    assign idx1  = index_of(r_newest, r_dd1);
    assign idx2  = index_of(r_newest, r_dd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_phase <= 24'd0;
        end else if (i_cmd.accept) begin
            r_wp    <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            if (r_fill != (AW+1)'(DELAY_DEPTH)) r_fill <= r_fill + (AW+1)'(1);
            r_phase <= (i_ratio != dlps_pkg::UNITY_RATIO) ? r_phase + i_inc : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wp] <= i_in_sample;
            r_newest    <= r_wp;
        end
        r_tap1 <= tap1;
        r_tap2 <= {1'b0, tap2};
        r_d1   <= delay_of(r_tap1, wsafe);
        r_d2   <= delay_of(r_tap2, wsafe);
        r_pa1  <= 35'(dlps_pkg::sine_at({1'b0, r_tap1[24:18]}))
                  * (35'h40000 - 35'(r_tap1[17:0]));
        r_pa2  <= 35'(dlps_pkg::sine_at({1'b0, r_tap2[24:18]}))
                  * (35'h40000 - 35'(r_tap2[17:0]));
        r_pb1  <= 34'(dlps_pkg::sine_at(8'(r_tap1[24:18]) + 8'd1)) * 34'(r_tap1[17:0]);
        r_pb2  <= 34'(dlps_pkg::sine_at(8'(r_tap2[24:18]) + 8'd1)) * 34'(r_tap2[17:0]);
        r_q1   <= quot_of(r_d1);
        r_q2   <= quot_of(r_d2);
        r_w1   <= 16'((36'(r_pa1) + 36'(r_pb1)) >> 18);
        r_w2   <= 16'((36'(r_pa2) + 36'(r_pb2)) >> 18);
        r_dd1  <= mod_of(r_d1, r_q1);
        r_dd2  <= mod_of(r_d2, r_q2);
        r_rd1  <= r_mem[idx1];
        r_rd2  <= r_mem[idx2];
        r_v1   <= CW'(r_dd1) < CW'(r_fill);
        r_v2   <= CW'(r_dd2) < CW'(r_fill);
        r_m1   <= (r_v1 ? 41'(r_rd1) : 41'sd0) * $signed({25'd0, r_w1});
        r_m2   <= (r_v2 ? 41'(r_rd2) : 41'sd0) * $signed({25'd0, r_w2});
    end

    logic signed [41:0] acc;
    logic signed [26:0] rnd;

    assign acc = 42'(r_m1) + 42'(r_m2) + 42'sd16384;
    assign rnd = 27'(acc >>> 15);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (rnd > 27'sd8388607) begin
                r_out <= 24'sh7FFFFF;
            end else if (rnd < -27'sd8388608) begin
                r_out <= 24'sh800000;
            end else begin
                r_out <= rnd[23:0];
            end
        end
    end

    assign o_out_sample = r_out;

endmodule

/* rtl/delay_line_pitch_shifter_core.sv */
// ----------------------------------------------------------------------------
// Delay-line pitch shifter core
// Two crossfaded taps over a circular delay memory, with an APB register port.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_in_sample
//   output    out        o_out_valid / i_out_ready o_out_sample
//   config    in         psel, penable, pwrite     paddr, pwdata / prdata
//
// Each word is accepted in IDLE and then steps through TAP, MUL, QUOT, MOD,
// READ, MAC and SUM. A register write starts a divide for the phase
// increment in the bit-serial divider; no word is accepted until it finishes.
// Memory entries are tracked by a fill count.
// A stalled output holds one result while the next word is processed.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter_core #(
    parameter int DELAY_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_in_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_out_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]    r_ratio;
    logic [11:0]    r_win;
    logic           r_start;
    logic           wr;
    logic           div_busy;
    logic [23:0]    inc;
    logic [15:0]    dev;
    logic [11:0]    wsafe;
    dlps_pkg::t_cmd cmd;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {20'd0, r_win} : {16'd0, r_ratio};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= dlps_pkg::RATIO_RESET;
            r_win   <= dlps_pkg::WIN_RESET;
            r_start <= 1'b0;
        end else begin
            r_start <= wr;
            if (wr && !paddr[2]) r_ratio <= pwdata[15:0];
            if (wr && paddr[2])  r_win   <= pwdata[11:0];
        end
    end

    assign dev   = (r_ratio > dlps_pkg::UNITY_RATIO) ? r_ratio - dlps_pkg::UNITY_RATIO
                                                     : dlps_pkg::UNITY_RATIO - r_ratio;
    assign wsafe = (r_win == 12'd0) ? 12'd1 : r_win;

    dlps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_numer ({1'b0, dev, 13'd0} + 30'(wsafe)),
        .i_denom ({wsafe, 1'b0}),
        .o_busy  (div_busy),
        .o_quot  (inc)
    );

    dlps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_busy      (div_busy || r_start || wr),
        .o_cmd       (cmd)
    );

    dlps_dp #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_sample  (i_in_sample),
        .i_ratio      (r_ratio),
        .i_win        (r_win),
        .i_inc        (inc),
        .o_out_sample (o_out_sample)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch shifter core testbench
// Streams audio words through the core under several pitch and window
// settings and compares each output word with a bit-exact predictor.
// ----------------------------------------------------------------------------
class shift_scoreboard;
    logic signed [23:0] delay_mem [4096];
    logic [11:0] wr_ptr;
    logic [23:0] phase;
    logic [15:0] ratio;
    logic [11:0] window;
    logic [23:0] phase_step;
    logic signed [23:0] pending [$];
    int errors;

    function void clear();
        foreach (delay_mem[k]) delay_mem[k] = '0;
        wr_ptr = '0;
        phase = '0;
        ratio = dlps_pkg::RATIO_RESET;
        window = dlps_pkg::WIN_RESET;
        errors = 0;
        pending.delete();
        calc_step();
    endfunction

    function void calc_step();
        longint unsigned w, dev, q;
        w = (window == 0) ? 1 : window;
        dev = (ratio > dlps_pkg::UNITY_RATIO) ? ratio - dlps_pkg::UNITY_RATIO
                                              : dlps_pkg::UNITY_RATIO - ratio;
        q = (dev * 8192 + w) / (2 * w);
        phase_step = q[23:0];
    endfunction

    function void set_ratio(logic [15:0] v);
        ratio = v;
        calc_step();
    endfunction

    function void set_window(logic [11:0] v);
        window = v;
        calc_step();
    endfunction

    function longint unsigned sine_pt(int unsigned i);
        if (i > 64) i = 64;
        return (i <= 32) ? dlps_pkg::SINE_Q15[i] : dlps_pkg::SINE_Q15[64 - i];
    endfunction

    function longint signed tap_product(logic [24:0] tap, logic [11:0] newest);
        longint unsigned w, d, a, b, fr, wt;
        logic [11:0] idx;
        w = (window == 0) ? 1 : window;
        d = (longint'(tap) * w + (1 << 23)) >> 24;
        idx = newest - d[11:0];
        fr = tap[17:0];
        a = sine_pt(tap >> 18);
        b = sine_pt((tap >> 18) + 1);
        wt = (a * ((1 << 18) - fr) + b * fr) >> 18;
        return longint'(delay_mem[idx]) * longint'(wt);
    endfunction

    function void note_input(logic signed [23:0] s);
        logic [24:0] tap1, tap2;
        logic [11:0] newest;
        longint signed acc, v;
        if (ratio != dlps_pkg::UNITY_RATIO) phase = phase + phase_step;
        else phase = '0;
        tap1 = (ratio > dlps_pkg::UNITY_RATIO) ? 25'h1000000 - phase : {1'b0, phase};
        tap2 = {1'b0, tap1[23:0] + 24'h800000};
        newest = wr_ptr;
        delay_mem[newest] = s;
        wr_ptr = wr_ptr + 1;
        acc = tap_product(tap1, newest) + tap_product(tap2, newest);
        v = (acc + 16384) >>> 15;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        pending.push_back(v[23:0]);
    endfunction

    task check_output(logic signed [23:0] got);
        logic signed [23:0] want;
        if (pending.size() == 0) begin
            report_error($sformatf("unexpected output word %0d", got));
        end else begin
            want = pending.pop_front();
            if (got !== want)
                report_error($sformatf("out_sample %0d, expected %0d", got, want));
        end
    endtask

    task report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] ADDR_RATIO = 3'd0;
    localparam logic [2:0] ADDR_WINDOW = 3'd4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [23:0] i_in_sample = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [23:0] o_out_sample;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    shift_scoreboard board;
    int idle_count;
    bit sink_pause;
    int sink_wait;
    bit seen_valid;

    delay_line_pitch_shifter_core dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_out_ready && o_out_valid) board.check_output(o_out_sample);
        if (i_rst_n && i_in_valid && o_in_ready) board.note_input(i_in_sample);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side stalls at random, with calm stretches when paused.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_wait = $urandom_range(0, 6);
            seen_valid = 1'b0;
        end else begin
            if (i_out_ready && seen_valid) begin
                sink_wait = sink_pause ? 0 : $urandom_range(0, 6);
            end else if (o_out_valid && sink_wait > 0) begin
                sink_wait--;
            end
            i_out_ready <= (sink_wait == 0);
            seen_valid = o_out_valid;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_RATIO) board.set_ratio(data[15:0]);
        else board.set_window(data[11:0]);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(input logic signed [23:0] s, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        unique case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] ratios [6];
        logic [11:0] windows [6];
        board = new();
        board.clear();
        idle_count = 0;
        ratios = '{16'd4096, 16'd8192, 16'd2048, 16'd65535, 16'd0, 16'd4097};
        windows = '{12'd1056, 12'd64, 12'd4095, 12'd1, 12'd0, 12'd37};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed words at reset settings: extremes and alternating bits.
        send_word(24'sh7FFFFF, 1'b1);
        send_word(24'sh7FFFFF, 1'b1);
        send_word(24'sh800000, 1'b0);
        send_word(24'sh800000, 1'b1);
        send_word(24'sh000000, 1'b0);
        send_word(24'shAAAAAA, 1'b0);
        send_word(24'sh555555, 1'b0);
        send_word(-24'sd1, 1'b0);
        drain();
        // Largest up shift with a window of one, on alternating extreme words.
        write_reg(ADDR_WINDOW, 32'd1);
        write_reg(ADDR_RATIO, 32'd65535);
        for (int k = 0; k < 8; k++) send_word(k[0] ? 24'sh7FFFFF : 24'sh800000, 1'b0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            int n;
            write_reg(ADDR_RATIO, (ph < 6) ? 32'(ratios[ph]) : $urandom_range(0, 65535));
            write_reg(ADDR_WINDOW, (ph < 6) ? 32'(windows[ph]) : $urandom_range(0, 4095));
            sink_pause = (ph % 4 == 3);
            n = (ph == 2) ? 250 : 90;
            for (int k = 0; k < n; k++) send_word(rand_sample(), sink_pause);
            drain();
        end
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
